FILE: rtl/blkalloc_pkg.sv
// Package for the block allocation bitmap.
// Holds request and status codes and the controller state type.
// No dependencies.
`timescale 1ns / 1ps

package blkalloc_pkg;

  localparam logic [2:0] REQ_MARK      = 3'd0;
  localparam logic [2:0] REQ_UNMARK    = 3'd1;
  localparam logic [2:0] REQ_TEST      = 3'd2;
  localparam logic [2:0] REQ_MARK_RUN  = 3'd3;
  localparam logic [2:0] REQ_UNMARK_RUN = 3'd4;
  localparam logic [2:0] REQ_TEST_RUN  = 3'd5;
  localparam logic [2:0] REQ_FIND      = 3'd6;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_RANGE  = 2'd1;
  localparam logic [1:0] ST_NOFREE = 2'd2;

  localparam logic CFG_FIRST = 1'b0;
  localparam logic CFG_LAST  = 1'b1;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_PREP,
    S_CHK,
    S_WRD,
    S_WMOD,
    S_S1,
    S_S2,
    S_S3,
    S_S4,
    S_RD,
    S_SCAN,
    S_SFIN
  } state_e;

endpackage

FILE: rtl/block_allocation_bitmap.sv
// Block allocation bitmap: used/free bit per block, kept in one word-wide RAM.
// Searches read one RAM word at a time, then scan it 8 bits a cycle.
// One request in flight; results cannot be stalled. Depends on blkalloc_pkg.
// After reset a clearing pass writes (MAP_BITS+63)/64 words (one a cycle); busy
// stays high until it is done.
`timescale 1ns / 1ps

module block_allocation_bitmap #(
  parameter int MAP_BITS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type_i,
  input  logic [31:0] block_number_i,
  input  logic [12:0] run_length_i,
  input  logic [31:0] search_limit_i,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic        flag_o,
  output logic [31:0] found_block_o
);
  import blkalloc_pkg::*;

  localparam int MAP_WORDS = (MAP_BITS + 63) / 64;
  localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int OFFW = $clog2(MAP_BITS) + 1;
  localparam logic [33:0] MAP_BITS_W = 34'(MAP_BITS);
  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

  state_e state_q, state_d;

  logic [63:0] mem [MAP_WORDS];
  logic [63:0] rdata_q;
  logic        mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [63:0] mem_wd;

  logic [31:0] first_q, last_q;
  logic [AW-1:0] clr_q, clr_d;
  logic        done_q, done_d;

  logic [2:0]  req_q, req_d;
  logic [31:0] b_q, b_d, lim_q, lim_d, lo_q, lo_d, lm_q, lm_d;
  logic [12:0] n_q, n_d, cnt_q, cnt_d;
  logic [33:0] off_q, off_d, endb_q, endb_d, e_q, e_d, em_q, em_d, hm_q, hm_d, hi_q, hi_d;
  logic        blt_q, blt_d, go_q, go_d;
  logic [OFFW-1:0] cur_q, cur_d, endo_q, endo_d, fpos_q, fpos_d;
  logic [1:0]  status_q, status_d;
  logic        flag_q, flag_d;
  logic [31:0] found_q, found_d;

  // decision terms
  logic        span1, spann, lastw, fnd, single;
  logic [33:0] offn;
  logic [AW-1:0] wcur, wend;
  logic [5:0]  lo_bit, hi_bit;
  logic [63:0] mask;
  logic [OFFW-1:0] base, next_base, pos, fpos;
  logic [12:0] c;

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign flag_o        = flag_q;
  assign found_block_o = found_q;

  always_comb begin
    span1  = !blt_q && (b_q <= last_q) && (off_q < MAP_BITS_W);
    offn   = off_q + 34'(n_q);
    spann  = (n_q == '0) ? span1
           : (!blt_q && (endb_q <= {2'b00, last_q}) && (offn <= MAP_BITS_W));
    single = (req_q == REQ_MARK) || (req_q == REQ_UNMARK) || (req_q == REQ_TEST);
    wcur   = cur_q[6 +: AW];
    wend   = endo_q[6 +: AW];
    lastw  = (wcur == wend);
    lo_bit = cur_q[5:0];
    hi_bit = lastw ? endo_q[5:0] : 6'd63;
    mask   = ({64{1'b1}} << lo_bit) & ({64{1'b1}} >> (6'd63 - hi_bit));

    // zero-run counter over one aligned byte of the fetched word
    base = {cur_q[OFFW-1:3], 3'b000};
    next_base = base + OFFW'(8);
    c    = cnt_q;
    fnd  = 1'b0;
    fpos = base;
    pos  = base;
    for (int k = 0; k < 8; k++) begin
      pos = base + OFFW'(k);
      if (!fnd && (pos >= cur_q) && (pos <= endo_q)) begin
        if (rdata_q[pos[5:0]]) c = '0;
        else c = c + 13'd1;
        if (c >= n_q) begin
          fnd  = 1'b1;
          fpos = pos;
        end
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:  if (clr_q == LAST_WORD) state_d = S_IDLE;
      S_IDLE: if (start) state_d = S_PREP;
      S_PREP: state_d = S_CHK;
      S_CHK: begin
        priority if (single) state_d = span1 ? S_WRD : S_IDLE;
        else if (req_q == REQ_MARK_RUN || req_q == REQ_UNMARK_RUN || req_q == REQ_TEST_RUN)
          state_d = (spann && n_q != '0) ? S_WRD : S_IDLE;
        else if (req_q == REQ_FIND) state_d = S_S1;
        else state_d = S_IDLE;
      end
      S_WRD: state_d = S_WMOD;
      S_WMOD: begin
        if (single || lastw || (req_q == REQ_TEST_RUN && |(rdata_q & mask)))
          state_d = S_IDLE;
        else
          state_d = S_WRD;
      end
      S_S1: state_d = S_S2;
      S_S2: state_d = S_S3;
      S_S3: state_d = S_S4;
      S_S4: state_d = (go_q && ({2'b00, lo_q} <= hi_q) && n_q != '0) ? S_RD : S_IDLE;
      S_RD: state_d = S_SCAN;
      S_SCAN: begin
        priority if (fnd) state_d = S_SFIN;
        else if (next_base > endo_q) state_d = S_IDLE;
        else if (next_base[5:0] == 6'd0) state_d = S_RD;
        else state_d = S_SCAN;
      end
      S_SFIN: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    clr_d = clr_q;  done_d = 1'b0;
    req_d = req_q;  b_d = b_q;  n_d = n_q;  lim_d = lim_q;
    off_d = off_q;  blt_d = blt_q;  endb_d = endb_q;  e_d = e_q;  lo_d = lo_q;
    em_d = em_q;  go_d = go_q;  hm_d = hm_q;  lm_d = lm_q;  hi_d = hi_q;
    cur_d = cur_q;  endo_d = endo_q;  cnt_d = cnt_q;  fpos_d = fpos_q;
    status_d = status_q;  flag_d = flag_q;  found_d = found_q;
    mem_we = 1'b0;  mem_wa = wcur;  mem_wd = rdata_q;
    mem_re = 1'b0;  mem_ra = wcur;

    unique case (state_q)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = '0;
        clr_d  = clr_q + AW'(1);
      end
      S_IDLE: begin
        if (start) begin
          req_d = req_type_i;
          b_d   = block_number_i;
          n_d   = run_length_i;
          lim_d = search_limit_i;
        end
      end
      S_PREP: begin
        off_d  = {2'b00, b_q} - {2'b00, first_q};
        blt_d  = (b_q < first_q);
        endb_d = {2'b00, b_q} + 34'(n_q) - 34'd1;
        e_d    = {2'b00, first_q} + MAP_BITS_W - 34'(n_q == '0);
        lo_d   = (b_q > first_q) ? b_q : first_q;
      end
      S_CHK: begin
        cur_d  = off_q[OFFW-1:0];
        endo_d = single ? off_q[OFFW-1:0] : OFFW'(offn - 34'd1);
        if (single) begin
          if (!span1) begin
            done_d = 1'b1; status_d = ST_RANGE; flag_d = 1'b0; found_d = '0;
          end
        end else if (req_q == REQ_MARK_RUN || req_q == REQ_UNMARK_RUN
                     || req_q == REQ_TEST_RUN) begin
          if (!spann) begin
            done_d = 1'b1; status_d = ST_RANGE; flag_d = 1'b0; found_d = '0;
          end else if (n_q == '0) begin
            done_d = 1'b1; status_d = ST_OK; found_d = '0;
            flag_d = (req_q == REQ_TEST_RUN);
          end
        end else if (req_q != REQ_FIND) begin
          done_d = 1'b1; status_d = ST_OK; flag_d = 1'b0; found_d = '0;
        end
      end
      S_WRD: mem_re = 1'b1;
      S_WMOD: begin
        cur_d = OFFW'({wcur + AW'(1), 6'b000000});
        if (single) begin
          done_d = 1'b1; status_d = ST_OK; found_d = '0;
          flag_d = rdata_q[lo_bit];
          mem_we = (req_q != REQ_TEST);
          mem_wd = (req_q == REQ_MARK) ? (rdata_q | mask) : (rdata_q & ~mask);
        end else if (req_q == REQ_TEST_RUN) begin
          if (|(rdata_q & mask)) begin
            done_d = 1'b1; status_d = ST_OK; found_d = '0; flag_d = 1'b0;
          end else if (lastw) begin
            done_d = 1'b1; status_d = ST_OK; found_d = '0; flag_d = 1'b1;
          end
        end else begin
          mem_we = 1'b1;
          mem_wd = (req_q == REQ_MARK_RUN) ? (rdata_q | mask) : (rdata_q & ~mask);
          if (lastw) begin
            done_d = 1'b1; status_d = ST_OK; found_d = '0; flag_d = 1'b0;
          end
        end
      end
      S_S1: em_d = (e_q > {2'b00, last_q}) ? {2'b00, last_q} : e_q;
      S_S2: begin
        go_d = (lim_q > b_q) && (em_q >= 34'(n_q));
        hm_d = em_q - 34'(n_q);
        lm_d = lim_q - 32'd1;
      end
      S_S3: hi_d = (hm_q > {2'b00, lm_q}) ? {2'b00, lm_q} : hm_q;
      S_S4: begin
        cnt_d  = '0;
        cur_d  = OFFW'({2'b00, lo_q} - {2'b00, first_q});
        endo_d = OFFW'(hi_q + 34'(n_q) - 34'd1 - {2'b00, first_q});
        if (!go_q || ({2'b00, lo_q} > hi_q)) begin
          done_d = 1'b1; status_d = ST_NOFREE; flag_d = 1'b0; found_d = '0;
        end else if (n_q == '0) begin
          done_d = 1'b1; status_d = ST_OK; flag_d = 1'b0; found_d = lo_q;
        end
      end
      S_RD: mem_re = 1'b1;
      S_SCAN: begin
        cnt_d  = c;
        fpos_d = fpos;
        cur_d  = next_base;
        if (!fnd && next_base > endo_q) begin
          done_d = 1'b1; status_d = ST_NOFREE; flag_d = 1'b0; found_d = '0;
        end
      end
      S_SFIN: begin
        done_d = 1'b1; status_d = ST_OK; flag_d = 1'b0;
        found_d = first_q + 32'(fpos_q) - 32'(n_q) + 32'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      done_q  <= 1'b0;
      first_q <= 32'd0;
      last_q  <= 32'd4095;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_FIRST) first_q <= cfg_data_i;
        if (cfg_index_i == CFG_LAST)  last_q  <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;  b_q <= b_d;  n_q <= n_d;  lim_q <= lim_d;
    off_q <= off_d;  blt_q <= blt_d;  endb_q <= endb_d;  e_q <= e_d;  lo_q <= lo_d;
    em_q <= em_d;  go_q <= go_d;  hm_q <= hm_d;  lm_q <= lm_d;  hi_q <= hi_d;
    cur_q <= cur_d;  endo_q <= endo_d;  cnt_q <= cnt_d;  fpos_q <= fpos_d;
    status_q <= status_d;  flag_q <= flag_d;  found_q <= found_d;
  end

  // occupancy RAM, registered read; each word is read then written
  // back before the next address is issued, so no forwarding is needed
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rdata_q <= mem[mem_ra];
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE) else $error("result strobe outside idle");

  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_CLR || state_q == S_WMOD))
    else $error("RAM write outside clear or modify");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (!flag_o && found_block_o == '0))
    else $error("error result carries data");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted transaction not busy");
`endif

endmodule
